// File: rtl/core/mbbc_pkg.sv
// Shared types, constants and coefficient tables for the band-pass biquad cascade.
package mbbc_pkg;

    // Channel count and the address width it needs
    localparam int CHANNELS = 32;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Fixed-point widths
    localparam int COEF_W = 24;            // Q2.22 coefficients
    localparam int W_W    = 40;            // delay words, 16 fraction bits
    localparam int ROW_W  = 4 * W_W;       // w1[n-1], w1[n-2], w2[n-1], w2[n-2]
    localparam int TERM_W = 42;            // rounded product, 16 fraction bits
    localparam int ACC_W  = 44;            // accumulators
    localparam int STEP_W = 4;

    // Sequencer steps
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;
    localparam logic [STEP_W-1:0] WB_STEP   = 4'd10;

    // Q2.22 coefficients: high-pass section, then low-pass section
    localparam logic signed [COEF_W-1:0] HP_A1 = -24'sd7497035;
    localparam logic signed [COEF_W-1:0] HP_A2 =  24'sd3388786;
    localparam logic signed [COEF_W-1:0] HP_B0 =  24'sd3770031;
    localparam logic signed [COEF_W-1:0] HP_B1 = -24'sd7540063;
    localparam logic signed [COEF_W-1:0] HP_B2 =  24'sd3770031;
    localparam logic signed [COEF_W-1:0] LP_A1 = -24'sd308801;
    localparam logic signed [COEF_W-1:0] LP_A2 =  24'sd723649;
    localparam logic signed [COEF_W-1:0] LP_B0 =  24'sd1152288;
    localparam logic signed [COEF_W-1:0] LP_B1 =  24'sd2304576;
    localparam logic signed [COEF_W-1:0] LP_B2 =  24'sd1152288;

    typedef struct packed {
        logic [4:0]         channel;
        logic signed [15:0] sample;
    } sample_item_t;

    typedef struct packed {
        logic [4:0]         channel_out;
        logic signed [15:0] filtered;
    } result_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CF_HP_A1,
        CF_HP_A2,
        CF_HP_B0,
        CF_HP_B1,
        CF_HP_B2,
        CF_LP_A1,
        CF_LP_A2,
        CF_LP_B0,
        CF_LP_B1,
        CF_LP_B2
    } coef_sel_t;

    typedef enum logic [2:0] {
        OP_W1A,
        OP_W1B,
        OP_W2A,
        OP_W2B,
        OP_W1N,
        OP_W2N
    } opnd_sel_t;

    typedef enum logic [1:0] {
        ACC_1,
        ACC_2,
        ACC_3
    } acc_sel_t;

    // One multiply-accumulate issued into the datapath
    typedef struct packed {
        logic      issue;
        coef_sel_t coef;
        opnd_sel_t opnd;
        acc_sel_t  acc;
        logic      sub;
    } mac_op_t;

    typedef struct packed {
        logic    capture;
        logic    load;
        mac_op_t mac;
        logic    write;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic chan_ok;
        logic out_free;
    } dp_sts_t;

    // Coefficient lookup
    function automatic logic signed [COEF_W-1:0] coef_value(coef_sel_t sel);
        logic signed [COEF_W-1:0] c;
        unique case (sel)
            CF_HP_A1: c = HP_A1;
            CF_HP_A2: c = HP_A2;
            CF_HP_B0: c = HP_B0;
            CF_HP_B1: c = HP_B1;
            CF_HP_B2: c = HP_B2;
            CF_LP_A1: c = LP_A1;
            CF_LP_A2: c = LP_A2;
            CF_LP_B0: c = LP_B0;
            CF_LP_B1: c = LP_B1;
            CF_LP_B2: c = LP_B2;
            default:  c = '0;
        endcase
        return c;
    endfunction

    // MAC schedule. ACC_1 builds w1, ACC_2 builds w2 (y1 folded in),
    // ACC_3 builds y2. The new w of a section is used once its last
    // accumulate has passed the accumulator and the saturation register.
    function automatic mac_op_t sched_op(logic [STEP_W-1:0] step);
        mac_op_t op;
        op = '{issue: 1'b0, coef: CF_HP_A1, opnd: OP_W1A, acc: ACC_1, sub: 1'b0};
        unique case (step)
            4'd0:  op = '{issue: 1'b1, coef: CF_HP_A1, opnd: OP_W1A, acc: ACC_1, sub: 1'b1};
            4'd1:  op = '{issue: 1'b1, coef: CF_HP_A2, opnd: OP_W1B, acc: ACC_1, sub: 1'b1};
            4'd2:  op = '{issue: 1'b1, coef: CF_LP_A1, opnd: OP_W2A, acc: ACC_2, sub: 1'b1};
            4'd3:  op = '{issue: 1'b1, coef: CF_LP_A2, opnd: OP_W2B, acc: ACC_2, sub: 1'b1};
            4'd4:  op = '{issue: 1'b1, coef: CF_HP_B1, opnd: OP_W1A, acc: ACC_2, sub: 1'b0};
            4'd5:  op = '{issue: 1'b1, coef: CF_HP_B0, opnd: OP_W1N, acc: ACC_2, sub: 1'b0};
            4'd6:  op = '{issue: 1'b1, coef: CF_HP_B2, opnd: OP_W1B, acc: ACC_2, sub: 1'b0};
            4'd7:  op = '{issue: 1'b1, coef: CF_LP_B1, opnd: OP_W2A, acc: ACC_3, sub: 1'b0};
            4'd8:  op = '{issue: 1'b1, coef: CF_LP_B2, opnd: OP_W2B, acc: ACC_3, sub: 1'b0};
            4'd10: op = '{issue: 1'b1, coef: CF_LP_B0, opnd: OP_W2N, acc: ACC_3, sub: 1'b0};
            default: op.issue = 1'b0;
        endcase
        return op;
    endfunction

endpackage

// File: rtl/core/mbbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/mbbc_datapath.sv
// Datapath: delay memory, pipelined multiply-accumulate, saturation and output register.
module mbbc_datapath
    import mbbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    output dp_sts_t      sts,
    input  sample_item_t sample_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    localparam logic signed [63:0]    PROD_RND = 64'sd2097152;
    localparam logic signed [ACC_W-1:0] OUT_RND = 44'sd32768;
    localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

    // Input item and per-channel bookkeeping
    sample_item_t        item_reg;
    logic [CH_AW-1:0]    addr_reg;
    logic                chan_ok_reg;
    logic [CHANNELS-1:0] valid_reg;

    // Delay operands, accumulators and saturated new delay words
    logic signed [W_W-1:0]   w1a_reg, w1b_reg, w2a_reg, w2b_reg;
    logic signed [W_W-1:0]   w1n_reg, w2n_reg;
    logic signed [ACC_W-1:0] acc1_reg, acc2_reg, acc3_reg;

    // Multiplier pipeline
    logic signed [43:0]       pp_hi_reg, pp_hi_next;
    logic signed [44:0]       pp_lo_reg, pp_lo_next;
    logic                     s1_valid_reg;
    acc_sel_t                 s1_acc_reg;
    logic                     s1_sub_reg;
    logic signed [TERM_W-1:0] term_reg, term_next;
    logic                     s2_valid_reg;
    acc_sel_t                 s2_acc_reg;
    logic                     s2_sub_reg;

    // Output register
    logic         out_valid_reg, out_valid_next;
    result_item_t out_item_reg, out_item_next;

    logic [ROW_W-1:0]         rd_row, wr_row;
    logic                     row_valid;
    logic signed [W_W-1:0]    opnd;
    logic signed [COEF_W-1:0] coef;
    logic signed [63:0]       prod;
    logic signed [ACC_W-1:0]  term_ext, acc_cur, acc_sum;
    logic signed [ACC_W-1:0]  out_sum;
    logic signed [27:0]       out_shift;
    logic signed [15:0]       out_sat;

    function automatic logic signed [W_W-1:0] sat40(logic signed [ACC_W-1:0] v);
        logic signed [W_W-1:0] r;
        if ((&v[ACC_W-1:W_W-1]) || !(|v[ACC_W-1:W_W-1]))
        begin
            r = v[W_W-1:0];
        end
        else
        begin
            r = v[ACC_W-1] ? W_MIN : W_MAX;
        end
        return r;
    endfunction

    // Delay memory: one row per channel
    mbbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (cmd.write),
        .wr_addr (addr_reg),
        .wr_data (wr_row),
        .rd_en   (cmd.capture),
        .rd_addr (CH_AW'(sample_item.channel)),
        .rd_data (rd_row)
    );

    assign wr_row    = {w1n_reg, w1a_reg, w2n_reg, w2a_reg};
    assign row_valid = valid_reg[addr_reg];

    // Capture the input item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg    <= sample_item;
            addr_reg    <= CH_AW'(sample_item.channel);
            chan_ok_reg <= (int'(sample_item.channel) < CHANNELS);
        end
    end

    // Mark a channel's row as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    // Multiplier operands
    always_comb
    begin
        unique case (cmd.mac.opnd)
            OP_W1A:  opnd = w1a_reg;
            OP_W1B:  opnd = w1b_reg;
            OP_W2A:  opnd = w2a_reg;
            OP_W2B:  opnd = w2b_reg;
            OP_W1N:  opnd = w1n_reg;
            OP_W2N:  opnd = w2n_reg;
            default: opnd = '0;
        endcase
        coef       = coef_value(cmd.mac.coef);
        pp_hi_next = coef * $signed(opnd[W_W-1:20]);
        pp_lo_next = coef * $signed({1'b0, opnd[19:0]});
    end

    // Combine partial products, round to 16 fraction bits
    always_comb
    begin
        prod      = ($signed({{20{pp_hi_reg[43]}}, pp_hi_reg}) <<< 20)
                  + $signed({{19{pp_lo_reg[44]}}, pp_lo_reg}) + PROD_RND;
        term_next = prod[63:22];
    end

    // Accumulate the rounded term into the selected accumulator
    always_comb
    begin
        term_ext = $signed({{(ACC_W-TERM_W){term_reg[TERM_W-1]}}, term_reg});
        unique case (s2_acc_reg)
            ACC_1:   acc_cur = acc1_reg;
            ACC_2:   acc_cur = acc2_reg;
            ACC_3:   acc_cur = acc3_reg;
            default: acc_cur = '0;
        endcase
        acc_sum = s2_sub_reg ? (acc_cur - term_ext) : (acc_cur + term_ext);
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.mac.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload, delay operands and accumulators
    always_ff @(posedge clk)
    begin
        pp_hi_reg  <= pp_hi_next;
        pp_lo_reg  <= pp_lo_next;
        s1_acc_reg <= cmd.mac.acc;
        s1_sub_reg <= cmd.mac.sub;
        term_reg   <= term_next;
        s2_acc_reg <= s1_acc_reg;
        s2_sub_reg <= s1_sub_reg;
        w1n_reg    <= sat40(acc1_reg);
        w2n_reg    <= sat40(acc2_reg);
        if (cmd.load)
        begin
            w1a_reg  <= row_valid ? rd_row[4*W_W-1:3*W_W] : '0;
            w1b_reg  <= row_valid ? rd_row[3*W_W-1:2*W_W] : '0;
            w2a_reg  <= row_valid ? rd_row[2*W_W-1:W_W]   : '0;
            w2b_reg  <= row_valid ? rd_row[W_W-1:0]       : '0;
            acc1_reg <= $signed({{(ACC_W-32){item_reg.sample[15]}}, item_reg.sample, 16'b0});
            acc2_reg <= '0;
            acc3_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            unique case (s2_acc_reg)
                ACC_1:   acc1_reg <= acc_sum;
                ACC_2:   acc2_reg <= acc_sum;
                ACC_3:   acc3_reg <= acc_sum;
                default: acc3_reg <= acc3_reg;
            endcase
        end
    end

    // Round y2 to an integer and saturate to 16 bits
    always_comb
    begin
        out_sum   = acc3_reg + OUT_RND;
        out_shift = out_sum[ACC_W-1:16];
        if ((&out_shift[27:15]) || !(|out_shift[27:15]))
        begin
            out_sat = out_shift[15:0];
        end
        else
        begin
            out_sat = out_shift[27] ? 16'sh8000 : 16'sh7fff;
        end
    end

    // Output register: load the result, drop valid once taken
    always_comb
    begin
        out_item_next = out_item_reg;
        if (cmd.out_load)
        begin
            out_item_next.channel_out = item_reg.channel;
            out_item_next.filtered    = chan_ok_reg ? out_sat : '0;
        end
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;
    assign sts.chan_ok  = chan_ok_reg;
    assign sts.out_free = !out_valid_reg || !result_stall;

    // A delay row is written back only for a channel that has one
    a_write_chan_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> chan_ok_reg)
        else $error("delay write for out-of-range channel");

    // A new item starts with the multiplier pipeline drained
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!s1_valid_reg && !s2_valid_reg && !cmd.mac.issue))
        else $error("item loaded while MAC pipeline busy");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && result_stall))
        else $error("output register overwritten while stalled");

endmodule

// File: rtl/core/mbbc_ctrl.sv
// Controller: accepts items and sequences the multiply-accumulate schedule.
module mbbc_ctrl
    import mbbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // State and step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = sts.chan_ok ? ST_RUN : ST_FINISH;
            end
            ST_RUN:
            begin
                cmd.mac   = sched_op(step_reg);
                cmd.write = (step_reg == WB_STEP);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    assign sample_stall = (state_reg != ST_IDLE);

    // An accepted item always moves on to the load step
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (state_reg == ST_LOAD))
        else $error("accepted item did not reach load");

    // Hold the finished result while the output register is occupied
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !sts.out_free) |=> (state_reg == ST_FINISH))
        else $error("left finish without an output slot");

endmodule

// File: rtl/core/multichannel_bandpass_biquad_cascade.sv
// Top level of the multichannel band-pass biquad cascade.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------
//  sample   | in        | sample_valid/_stall  | sample_item {channel, sample}
//  result   | out       | result_valid/_stall  | result_item {channel_out, filtered}
//
// One item runs from acceptance through the load of the channel's delay
// row, 13 steps of the shared 3-stage MAC pipeline (ten multiplies, one
// wait on the second section's saturated new delay word and two steps to
// drain the pipeline), and the output load; only then is the next item accepted.
// The output load waits for a free output register; it makes the result valid.
// Reset clears the per-channel valid bits, so every delay word reads zero
// until the channel is first filtered; no clearing pass is needed.
// A stalled result holds in the output register; a new item may be
// accepted meanwhile and waits in its finish state for the register.
module multichannel_bandpass_biquad_cascade
    import mbbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_item_t sample_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    mbbc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    mbbc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// File: tb/mbbc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the band-pass biquad cascade: predicts each filtered sample and checks it.
module mbbc_checker
    import mbbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    input  logic         sample_stall,
    input  sample_item_t sample_item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_item_t result_item,
    output int           fail_count,
    output int           outstanding
);

    // Q2.22 coefficients of the high-pass and low-pass sections
    localparam longint HPF_A1 = -7497035;
    localparam longint HPF_A2 =  3388786;
    localparam longint HPF_B0 =  3770031;
    localparam longint HPF_B1 = -7540063;
    localparam longint HPF_B2 =  3770031;
    localparam longint LPF_A1 = -308801;
    localparam longint LPF_A2 =  723649;
    localparam longint LPF_B0 =  1152288;
    localparam longint LPF_B1 =  2304576;
    localparam longint LPF_B2 =  1152288;

    localparam longint DELAY_MAX = 64'sd549755813887;
    localparam longint DELAY_MIN = -64'sd549755813888;

    // Per-channel delay words: d1 is w[n-1], d2 is w[n-2]
    longint hp_d1 [CHANNELS];
    longint hp_d2 [CHANNELS];
    longint lp_d1 [CHANNELS];
    longint lp_d2 [CHANNELS];

    result_item_t expected_results [$];
    int           mismatch_total;

    // Coefficient times delay word, rounded to 16 fraction bits
    function automatic longint mul_round(longint coef, longint w);
        return (coef * w + 64'sd2097152) >>> 22;
    endfunction

    function automatic longint clamp40(longint v);
        if (v > DELAY_MAX)
            return DELAY_MAX;
        if (v < DELAY_MIN)
            return DELAY_MIN;
        return v;
    endfunction

    // Run one sample through its channel's two sections and advance the delays
    function automatic result_item_t filter_sample(sample_item_t it);
        result_item_t r;
        longint       x;
        longint       w1_new;
        longint       y1;
        longint       w2_new;
        longint       y2;
        longint       q;
        int           c;
        c = int'(it.channel);
        x = longint'($signed(it.sample));
        r.channel_out = it.channel;
        r.filtered    = '0;
        if (c < CHANNELS)
        begin
            w1_new = clamp40((x <<< 16) - mul_round(HPF_A1, hp_d1[c])
                             - mul_round(HPF_A2, hp_d2[c]));
            y1 = mul_round(HPF_B0, w1_new) + mul_round(HPF_B1, hp_d1[c])
                 + mul_round(HPF_B2, hp_d2[c]);
            w2_new = clamp40(y1 - mul_round(LPF_A1, lp_d1[c])
                             - mul_round(LPF_A2, lp_d2[c]));
            y2 = mul_round(LPF_B0, w2_new) + mul_round(LPF_B1, lp_d1[c])
                 + mul_round(LPF_B2, lp_d2[c]);
            hp_d2[c] = hp_d1[c];
            hp_d1[c] = w1_new;
            lp_d2[c] = lp_d1[c];
            lp_d1[c] = w2_new;
            q = (y2 + 64'sd32768) >>> 16;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            r.filtered = q[15:0];
        end
        return r;
    endfunction

    // Check results against the oldest prediction, then predict new items
    always @(posedge clk or negedge rst_n)
    begin
        result_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                hp_d1[i] = 0;
                hp_d2[i] = 0;
                lp_d1[i] = 0;
                lp_d2[i] = 0;
            end
            expected_results.delete();
            mismatch_total = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: channel_out %0d filtered %0d",
                             $time, result_item.channel_out, $signed(result_item.filtered));
                    mismatch_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_item.channel_out !== want.channel_out)
                    begin
                        $display("%0t: channel_out expected %0d actual %0d",
                                 $time, want.channel_out, result_item.channel_out);
                        mismatch_total++;
                    end
                    if (result_item.filtered !== want.filtered)
                    begin
                        $display("%0t: filtered (channel %0d) expected %0d actual %0d",
                                 $time, want.channel_out, $signed(want.filtered),
                                 $signed(result_item.filtered));
                        mismatch_total++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                expected_results.push_back(filter_sample(sample_item));
            fail_count  <= mismatch_total;
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the band-pass biquad cascade: clock, reset, stimulus and verdict.
module tb;
    import mbbc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_stall;
    sample_item_t sample_item;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;

    int fail_count;
    int outstanding;
    int idle_pct;
    int stall_pct = 0;
    int cycle_count = 0;
    int tone_phase [32] = '{default: 0};

    multichannel_bandpass_biquad_cascade u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    mbbc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Stall the result side at the current phase's rate
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold valid low for random gaps, then offer the item until accepted
    task automatic send_sample(input logic [4:0] ch, input logic signed [15:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid        <= 1'b1;
        sample_item.channel <= ch;
        sample_item.sample  <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Stop sending until every predicted result has been received
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mix of full-range noise, extremes, small values and per-channel square waves
    function automatic logic signed [15:0] pick_sample(input logic [4:0] ch);
        logic signed [15:0] v;
        case ($urandom_range(9))
            0, 1:
            begin
                case ($urandom_range(3))
                    0:       v = 16'sh7FFF;
                    1:       v = 16'sh8000;
                    2:       v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
            end
            2:       v = 16'($urandom_range(200)) - 16'sd100;
            3, 4:
            begin
                v = ((tone_phase[ch] % 6) < 3) ? 16'sh7FFF : 16'sh8000;
                tone_phase[ch]++;
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // One stretch of random items, with a full drain halfway through
    task automatic run_phase(input int count, input int idle, input int stall);
        logic [4:0] ch;
        idle_pct  = idle;
        stall_pct <= stall;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1) == 0)
                ch = 5'($urandom_range(3));
            else
                ch = 5'($urandom_range(31));
            send_sample(ch, pick_sample(ch));
            if (i == count / 2)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_item  = '0;
        idle_pct     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes on the first and last channel
        send_sample(5'd0, 16'sh7FFF);
        send_sample(5'd0, 16'sh8000);
        send_sample(5'd0, 16'sh0000);
        send_sample(5'd0, 16'shFFFF);
        send_sample(5'd0, 16'sh7FFF);
        send_sample(5'd31, 16'sh8000);
        send_sample(5'd31, 16'sh7FFF);
        send_sample(5'd31, 16'sh0001);
        send_sample(5'd31, 16'sh8000);
        // Alternating bit patterns
        send_sample(5'b10101, 16'sh5555);
        send_sample(5'b01010, 16'shAAAA);
        // Full-scale square wave to drive the output into saturation
        for (int k = 0; k < 12; k++)
            send_sample(5'd7, ((k % 6) < 3) ? 16'sh7FFF : 16'sh8000);
        drain_results();

        run_phase(132, 0, 0);
        run_phase(132, 87, 0);
        run_phase(132, 0, 87);
        run_phase(132, 14, 14);

        // Let any stray result show up before the verdict
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
